/* rtl/core/h264_keyframe_segmenter_defines.svh */
// Assertion macros used by the keyframe segmenter top level.
`ifndef H264_KEYFRAME_SEGMENTER_DEFINES_SVH
`define H264_KEYFRAME_SEGMENTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HKS_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HKS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

/* rtl/core/hks_pkg.sv */
// Types and constants shared by the keyframe segmenter modules.
`default_nettype none

package hks_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int COUNT_W     = 32;
  localparam int PEND_W      = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [BYTE_W-1:0]  BYTE_ZERO    = 8'h00;
  localparam logic [BYTE_W-1:0]  BYTE_ONE     = 8'h01;
  localparam logic [BYTE_W-1:0]  NAL_SPS      = 8'h27;
  localparam logic [BYTE_W-1:0]  NAL_IDR      = 8'h25;
  localparam logic [31:0]        START_PREFIX = 32'h0000_0001;
  localparam logic [31:0]        RECENT_RESET = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0]   HDR_PREFIX_LEN = 6'd5;
  localparam logic [PEND_W-1:0]  PEND_FULL    = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_OPEN   = 32'd5;
  localparam logic [CFG_DATA_W-1:0] MAX_BYTES_RESET = 32'd67108864;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECORD_ENABLE     = 1'b0,
    REG_MAX_SEGMENT_BYTES = 1'b1
  } cfg_reg_t;

  // Front-end stream mode
  typedef enum logic [2:0] {
    MODE_SEEK  = 3'd0,
    MODE_SAVE  = 3'd1,
    MODE_WAIT  = 3'd2,
    MODE_REC   = 3'd3,
    MODE_CLOSE = 3'd4,
    MODE_STOP  = 3'd5
  } mode_t;

  // Back-end sequencer state
  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_HEAD = 3'd1,
    BK_RD   = 3'd2,
    BK_DATA = 3'd3,
    BK_CODE = 3'd4
  } back_state_t;

  typedef enum logic {
    CMD_EMIT = 1'b0,
    CMD_OPEN = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [BYTE_W-1:0]   data;
    logic [LEN_W-1:0]    len;
  } q_entry_t;

  typedef struct packed {
    logic                en;
    logic [LEN_W-1:0]    addr;
    logic [BYTE_W-1:0]   data;
  } hdr_wr_t;

  typedef struct packed {
    logic                en;
    logic [LEN_W-1:0]    addr;
  } hdr_rd_t;

endpackage

`default_nettype wire

/* rtl/core/hks_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hks_front.sv */
// Front end: configuration registers, start-code tracking, header capture and command issue.
`default_nettype none

module hks_front #(
  parameter int HEADER_DEPTH = 48
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hks_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hks_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [hks_pkg::BYTE_W-1:0]        in_byte,
  output logic                                   q_push,
  output hks_pkg::q_entry_t                      q_entry,
  input  wire logic                              q_full,
  output hks_pkg::hdr_wr_t                       hdr_wr,
  output logic [hks_pkg::LEN_W-1:0]              hdr_len
);

  logic                              record_enable;
  logic [hks_pkg::CFG_DATA_W-1:0]    max_segment_bytes;
  hks_pkg::mode_t                    mode, mode_next;
  logic [31:0]                       recent, recent_next;
  logic [hks_pkg::LEN_W-1:0]         hlen, hlen_next;
  logic [hks_pkg::COUNT_W-1:0]       count, count_next;
  logic [hks_pkg::PEND_W-1:0]        pend, pend_next;
  logic                              accept;
  logic                              prefix;
  logic                              key;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign prefix    = (recent == hks_pkg::START_PREFIX);
  assign key       = prefix && (in_byte == hks_pkg::NAL_IDR);
  assign hdr_len   = hlen;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      record_enable     <= 1'b0;
      max_segment_bytes <= hks_pkg::MAX_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hks_pkg::REG_RECORD_ENABLE:     record_enable     <= cfg_data[0];
        hks_pkg::REG_MAX_SEGMENT_BYTES: max_segment_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= hks_pkg::MODE_SEEK;
      recent <= hks_pkg::RECENT_RESET;
      hlen   <= '0;
      count  <= '0;
      pend   <= '0;
    end else begin
      mode   <= mode_next;
      recent <= recent_next;
      hlen   <= hlen_next;
      count  <= count_next;
      pend   <= pend_next;
    end
  end

  // Classify one byte: update mode, store header bytes, issue a command
  always_comb begin
    hks_pkg::mode_t            m;
    logic [hks_pkg::PEND_W-1:0] p;
    logic [hks_pkg::COUNT_W-1:0] count_inc;
    m           = mode;
    p           = pend;
    count_inc   = (count == hks_pkg::COUNT_MAX) ? count : count + 32'd1;
    mode_next   = mode;
    recent_next = recent;
    hlen_next   = hlen;
    count_next  = count;
    pend_next   = pend;
    q_push      = 1'b0;
    q_entry.kind = hks_pkg::CMD_EMIT;
    q_entry.data = in_byte;
    q_entry.len  = hlen;
    hdr_wr.en    = 1'b0;
    hdr_wr.addr  = hlen;
    hdr_wr.data  = recent[31:24];
    if (accept) begin
      // resume, or begin closing the current segment
      if (m == hks_pkg::MODE_STOP && record_enable) begin
        m = hks_pkg::MODE_WAIT;
      end
      if (m == hks_pkg::MODE_REC && (!record_enable || count > max_segment_bytes)) begin
        m = hks_pkg::MODE_CLOSE;
        p = '0;
      end
      mode_next = m;
      pend_next = p;
      case (m)
        hks_pkg::MODE_SEEK: begin
          if (prefix && in_byte == hks_pkg::NAL_SPS) begin
            hlen_next = hks_pkg::HDR_PREFIX_LEN;
            pend_next = '0;
            mode_next = hks_pkg::MODE_SAVE;
          end
        end
        hks_pkg::MODE_SAVE, hks_pkg::MODE_CLOSE: begin
          if (key) begin
            pend_next = '0;
            if (record_enable) begin
              q_push       = 1'b1;
              q_entry.kind = hks_pkg::CMD_OPEN;
              count_next   = hks_pkg::COUNT_OPEN;
              mode_next    = hks_pkg::MODE_REC;
            end else begin
              mode_next = hks_pkg::MODE_STOP;
            end
          end else if (p >= hks_pkg::PEND_FULL) begin
            if (m == hks_pkg::MODE_SAVE) begin
              // drop header bytes past the store
              if (hlen < hks_pkg::LEN_W'(HEADER_DEPTH)) begin
                hdr_wr.en = 1'b1;
                hlen_next = hlen + 6'd1;
              end
            end else begin
              q_push       = 1'b1;
              q_entry.data = recent[31:24];
              count_next   = count_inc;
            end
          end else begin
            pend_next = p + 3'd1;
          end
        end
        hks_pkg::MODE_WAIT: begin
          if (!record_enable) begin
            mode_next = hks_pkg::MODE_STOP;
          end else if (key) begin
            q_push     = 1'b1;
            q_entry.kind = hks_pkg::CMD_OPEN;
            count_next = hks_pkg::COUNT_OPEN;
            pend_next  = '0;
            mode_next  = hks_pkg::MODE_REC;
          end
        end
        hks_pkg::MODE_REC: begin
          q_push     = 1'b1;
          count_next = count_inc;
        end
        hks_pkg::MODE_STOP: ;
        default: mode_next = hks_pkg::MODE_SEEK;
      endcase
      recent_next = {recent[23:0], in_byte};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hks_fifo.sv */
// Command queue between the front end and the back end.
`default_nettype none

module hks_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire hks_pkg::q_entry_t push_entry,
  output logic                   full,
  input  wire logic              pop,
  output hks_pkg::q_entry_t      head,
  output logic                   empty
);

  hks_pkg::q_entry_t             slots [hks_pkg::QUEUE_DEPTH];
  logic [hks_pkg::QPTR_W-1:0]    wptr;
  logic [hks_pkg::QPTR_W-1:0]    rptr;
  logic [hks_pkg::QPTR_W:0]      fill;

  assign full  = (fill == (hks_pkg::QPTR_W+1)'(hks_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rptr];

  // Store a pushed entry
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + (hks_pkg::QPTR_W)'(1);
      end
      if (pop && !empty) begin
        rptr <= rptr + (hks_pkg::QPTR_W)'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + (hks_pkg::QPTR_W+1)'(1);
        2'b01:   fill <= fill - (hks_pkg::QPTR_W+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hks_back.sv */
// Back end: carries out queued commands and drives the output register.
`default_nettype none

module hks_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_empty,
  input  wire hks_pkg::q_entry_t            q_head,
  output logic                              q_pop,
  output hks_pkg::hdr_rd_t                  hdr_rd,
  input  wire logic [hks_pkg::BYTE_W-1:0]   hdr_data,
  output logic                              busy,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [hks_pkg::BYTE_W-1:0]        out_byte,
  output logic                              segment_start,
  output logic                              last
);

  hks_pkg::back_state_t          state, state_next;
  logic [hks_pkg::LEN_W-1:0]     idx, idx_next;
  logic [hks_pkg::LEN_W-1:0]     len, len_next;
  logic                          slot_free;
  logic                          load;
  logic [hks_pkg::BYTE_W-1:0]    load_byte;
  logic                          load_start;
  logic                          load_last;

  // First five header bytes: the start code and the 0x27 NAL header
  function automatic logic [hks_pkg::BYTE_W-1:0] head_byte(input logic [2:0] i);
    case (i)
      3'd3:    head_byte = hks_pkg::BYTE_ONE;
      3'd4:    head_byte = hks_pkg::NAL_SPS;
      default: head_byte = hks_pkg::BYTE_ZERO;
    endcase
  endfunction

  // Keyframe start code 00 00 00 01 25
  function automatic logic [hks_pkg::BYTE_W-1:0] key_byte(input logic [2:0] i);
    case (i)
      3'd3:    key_byte = hks_pkg::BYTE_ONE;
      3'd4:    key_byte = hks_pkg::NAL_IDR;
      default: key_byte = hks_pkg::BYTE_ZERO;
    endcase
  endfunction

  assign slot_free = !out_valid || out_ready;
  assign busy      = (state != hks_pkg::BK_IDLE);

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hks_pkg::BK_IDLE;
      idx   <= '0;
      len   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      len   <= len_next;
    end
  end

  // Next state and output loads
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    len_next    = len;
    q_pop       = 1'b0;
    hdr_rd.en   = 1'b0;
    hdr_rd.addr = idx;
    load        = 1'b0;
    load_byte   = q_head.data;
    load_start  = 1'b0;
    load_last   = 1'b0;
    case (state)
      hks_pkg::BK_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop = 1'b1;
          if (q_head.kind == hks_pkg::CMD_EMIT) begin
            load      = 1'b1;
            load_last = 1'b1;
          end else begin
            len_next   = q_head.len;
            idx_next   = '0;
            state_next = hks_pkg::BK_HEAD;
          end
        end
      end
      hks_pkg::BK_HEAD: begin
        if (slot_free) begin
          load       = 1'b1;
          load_byte  = head_byte(idx[2:0]);
          load_start = (idx == '0);
          if (idx == hks_pkg::HDR_PREFIX_LEN - 6'd1) begin
            if (len == hks_pkg::HDR_PREFIX_LEN) begin
              idx_next   = '0;
              state_next = hks_pkg::BK_CODE;
            end else begin
              idx_next   = idx + 6'd1;
              state_next = hks_pkg::BK_RD;
            end
          end else begin
            idx_next = idx + 6'd1;
          end
        end
      end
      hks_pkg::BK_RD: begin
        hdr_rd.en  = 1'b1;
        state_next = hks_pkg::BK_DATA;
      end
      hks_pkg::BK_DATA: begin
        if (slot_free) begin
          load      = 1'b1;
          load_byte = hdr_data;
          if (idx + 6'd1 == len) begin
            idx_next   = '0;
            state_next = hks_pkg::BK_CODE;
          end else begin
            idx_next   = idx + 6'd1;
            state_next = hks_pkg::BK_RD;
          end
        end
      end
      hks_pkg::BK_CODE: begin
        if (slot_free) begin
          load      = 1'b1;
          load_byte = key_byte(idx[2:0]);
          if (idx == hks_pkg::HDR_PREFIX_LEN - 6'd1) begin
            load_last  = 1'b1;
            idx_next   = '0;
            state_next = hks_pkg::BK_IDLE;
          end else begin
            idx_next = idx + 6'd1;
          end
        end
      end
      default: state_next = hks_pkg::BK_IDLE;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= load_byte;
      segment_start <= load_start;
      last          <= load_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/h264_keyframe_segmenter.sv */
// Top level of the H.264 keyframe segmenter.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//  in       | in_valid/in_ready   | in_byte
//  out      | out_valid/out_ready | out_byte, segment_start, last
//
// A stream byte is taken each cycle while the four-entry command queue has room.
// A passed-through byte gives one result, loaded into the output register once popped.
// A keyframe opens a segment: the back-end sequencer loads the five prefix bytes, then
// each stored header byte as one RAM read then one output load, then the keyframe start code.
// Synchronous reset clears control state; the header RAM is not cleared.
// A stalled output holds the back end; the front end stalls only once the queue fills.
`default_nettype none
`include "h264_keyframe_segmenter_defines.svh"

module h264_keyframe_segmenter #(
  parameter int HEADER_DEPTH = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hks_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [hks_pkg::BYTE_W-1:0]     in_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [hks_pkg::BYTE_W-1:0]          out_byte,
  output logic                                segment_start,
  output logic                                last
);

  localparam int AW = $clog2(HEADER_DEPTH);

  logic                          q_push;
  hks_pkg::q_entry_t             q_entry;
  logic                          q_full;
  logic                          q_pop;
  hks_pkg::q_entry_t             q_head;
  logic                          q_empty;
  hks_pkg::hdr_wr_t              hdr_wr;
  hks_pkg::hdr_rd_t              hdr_rd;
  logic [hks_pkg::BYTE_W-1:0]    hdr_data;
  logic [hks_pkg::LEN_W-1:0]     hdr_len;
  logic                          back_busy;

  hks_front #(
    .HEADER_DEPTH(HEADER_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .q_full    (q_full),
    .hdr_wr    (hdr_wr),
    .hdr_len   (hdr_len)
  );

  hks_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  hks_ram #(
    .WIDTH (hks_pkg::BYTE_W),
    .DEPTH (HEADER_DEPTH)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (hdr_wr.en),
    .wr_addr (hdr_wr.addr[AW-1:0]),
    .wr_data (hdr_wr.data),
    .rd_en   (hdr_rd.en),
    .rd_addr (hdr_rd.addr[AW-1:0]),
    .rd_data (hdr_data)
  );

  hks_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .hdr_rd        (hdr_rd),
    .hdr_data      (hdr_data),
    .busy          (back_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .segment_start (segment_start),
    .last          (last)
  );

  // Header reads stay within the stored, RAM-held part of the header
  `HKS_ASSERT_IMPL(a_rd_in_header, clk, rst, hdr_rd.en, (hdr_rd.addr >= hks_pkg::HDR_PREFIX_LEN) && (hdr_rd.addr < hdr_len), "header read outside stored bytes")

  // Header is only written before any command has been issued
  `HKS_ASSERT_IMPL(a_wr_before_open, clk, rst, hdr_wr.en, !back_busy && q_empty, "header written while a segment is in flight")

  // Taking an open command starts the replay sequencer
  `HKS_ASSERT_NEXT(a_open_starts, clk, rst, q_pop && (q_head.kind == hks_pkg::CMD_OPEN), back_busy, "open command did not start replay")

  // A segment opens on a zero byte that is never the last result
  `HKS_ASSERT_IMPL(a_start_byte, clk, rst, out_valid && segment_start, (out_byte == hks_pkg::BYTE_ZERO) && !last, "bad segment start byte")

endmodule

`default_nettype wire

/* tb/h264_keyframe_segmenter_checker.sv */
// Checker for the keyframe segmenter: tracks the stream, predicts segment bytes, compares results.
`timescale 1ns / 1ps

module h264_keyframe_segmenter_checker #(
  parameter int HEADER_DEPTH = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [hks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hks_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [hks_pkg::BYTE_W-1:0]     in_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [hks_pkg::BYTE_W-1:0]     out_byte,
  input  logic                           segment_start,
  input  logic                           last,
  output int                             fail_count,
  output int                             outstanding
);
  import hks_pkg::*;

  localparam int MAX_BURST    = HEADER_DEPTH + 5;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              seg_start;
    logic              last;
  } seg_byte_t;

  // Shadow of the segmenter state and its registers
  mode_t               mode_q;
  logic [31:0]         recent_q;
  logic [BYTE_W-1:0]   hdr_mem [HEADER_DEPTH];
  logic [LEN_W-1:0]    hdr_len;
  logic [COUNT_W-1:0]  seg_bytes_q;
  logic [PEND_W-1:0]   held_q;
  logic                rec_en_q;
  logic [CFG_DATA_W-1:0] max_bytes_q;

  // Segment bytes caused by one stream byte, then the queue still owed by the block
  seg_byte_t burst [MAX_BURST];
  int        burst_n;
  seg_byte_t seg_bytes_due [$];

  int fails        = 0;
  int results_seen = 0;

  task automatic emit(input logic [BYTE_W-1:0] d, input logic s);
    burst[burst_n].data      = d;
    burst[burst_n].seg_start = s;
    burst[burst_n].last      = 1'b0;
    burst_n++;
  endtask

  task automatic count_segment_byte();
    if (seg_bytes_q != COUNT_MAX)
      seg_bytes_q++;
  endtask

  // Replay the stored header, then the keyframe start code
  task automatic open_segment();
    logic first;
    first = 1'b1;
    for (int i = 0; i < int'(hdr_len); i++) begin
      emit(hdr_mem[i], first);
      first = 1'b0;
    end
    emit(BYTE_ZERO, first);
    emit(BYTE_ZERO, 1'b0);
    emit(BYTE_ZERO, 1'b0);
    emit(BYTE_ONE, 1'b0);
    emit(NAL_IDR, 1'b0);
    seg_bytes_q = COUNT_OPEN;
    held_q      = '0;
    mode_q      = MODE_REC;
  endtask

  task automatic predict_byte(input logic [BYTE_W-1:0] b);
    logic              at_prefix;
    logic [BYTE_W-1:0] oldest;
    at_prefix = (recent_q == START_PREFIX);
    oldest    = recent_q[31:24];
    burst_n   = 0;

    // Leave stop on enable; start closing on disable or once the segment is full
    if (mode_q == MODE_STOP && rec_en_q)
      mode_q = MODE_WAIT;
    if (mode_q == MODE_REC && (!rec_en_q || seg_bytes_q > max_bytes_q)) begin
      mode_q = MODE_CLOSE;
      held_q = '0;
    end

    case (mode_q)
      MODE_SEEK: begin
        if (at_prefix && b == NAL_SPS) begin
          hdr_mem[0] = BYTE_ZERO;
          hdr_mem[1] = BYTE_ZERO;
          hdr_mem[2] = BYTE_ZERO;
          hdr_mem[3] = BYTE_ONE;
          hdr_mem[4] = NAL_SPS;
          hdr_len    = HDR_PREFIX_LEN;
          held_q     = '0;
          mode_q     = MODE_SAVE;
        end
      end
      MODE_SAVE: begin
        if (at_prefix && b == NAL_IDR) begin
          held_q = '0;
          if (rec_en_q)
            open_segment();
          else
            mode_q = MODE_STOP;
        end else if (held_q >= PEND_FULL) begin
          // Store the byte four behind; drop it once the header is full
          if (int'(hdr_len) < HEADER_DEPTH) begin
            hdr_mem[hdr_len] = oldest;
            hdr_len++;
          end
        end else begin
          held_q++;
        end
      end
      MODE_WAIT: begin
        if (!rec_en_q)
          mode_q = MODE_STOP;
        else if (at_prefix && b == NAL_IDR)
          open_segment();
      end
      MODE_REC: begin
        emit(b, 1'b0);
        count_segment_byte();
      end
      MODE_CLOSE: begin
        if (at_prefix && b == NAL_IDR) begin
          held_q = '0;
          if (rec_en_q)
            open_segment();
          else
            mode_q = MODE_STOP;
        end else if (held_q >= PEND_FULL) begin
          emit(oldest, 1'b0);
          count_segment_byte();
        end else begin
          held_q++;
        end
      end
      MODE_STOP: ;
      default: mode_q = MODE_SEEK;
    endcase

    recent_q = {recent_q[23:0], b};
    for (int i = 0; i < burst_n; i++) begin
      burst[i].last = (i == burst_n - 1);
      seg_bytes_due.push_back(burst[i]);
    end
  endtask

  // Apply register writes, predict accepted bytes, check accepted results
  always @(posedge clk) begin : track
    seg_byte_t want;
    if (rst) begin
      mode_q      = MODE_SEEK;
      recent_q    = RECENT_RESET;
      hdr_len     = '0;
      seg_bytes_q = '0;
      held_q      = '0;
      rec_en_q    = 1'b0;
      max_bytes_q = MAX_BYTES_RESET;
      seg_bytes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_RECORD_ENABLE:     rec_en_q    = cfg_data[0];
          REG_MAX_SEGMENT_BYTES: max_bytes_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_byte(in_byte);
      if (out_valid && out_ready) begin
        if (seg_bytes_due.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("result %0d not predicted: out_byte=%02h segment_start=%0b last=%0b",
                     results_seen, out_byte, segment_start, last);
        end else begin
          want = seg_bytes_due.pop_front();
          if (want.data !== out_byte || want.seg_start !== segment_start ||
              want.last !== last) begin
            fails++;
            if (fails <= REPORT_LIMIT)
              $display("result %0d mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       results_seen, want.data, want.seg_start, want.last,
                       out_byte, segment_start, last);
          end
        end
        results_seen++;
      end
    end
    fail_count  <= fails;
    outstanding <= seg_bytes_due.size();
  end

endmodule

/* tb/h264_keyframe_segmenter_test.sv */
// Testbench top for the keyframe segmenter: drives stream and registers, gives the verdict.
`timescale 1ns / 1ps

module h264_keyframe_segmenter_test;
  import hks_pkg::*;

  localparam int HEADER_DEPTH  = 48;
  localparam int RANDOM_BYTES  = 215;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [BYTE_W-1:0] NAL_SLICE = 8'h21;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_byte       = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [BYTE_W-1:0]     out_byte;
  logic                  segment_start;
  logic                  last;

  int fail_count;
  int outstanding;
  int bytes_sent  = 0;
  int idle_cycles = 0;
  bit no_gaps     = 1'b0;

  h264_keyframe_segmenter #(
    .HEADER_DEPTH(HEADER_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .segment_start(segment_start),
    .last         (last)
  );

  h264_keyframe_segmenter_checker #(
    .HEADER_DEPTH(HEADER_DEPTH)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .segment_start(segment_start),
    .last         (last),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run if no transaction moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL h264_keyframe_segmenter");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Accept results, stalling a random number of cycles before each one
  initial begin : take_results
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  function automatic logic [BYTE_W-1:0] stream_byte(input bit zeros_ok);
    if (zeros_ok && $urandom_range(0, 3) == 0)
      return BYTE_ZERO;
    return zeros_ok ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 255));
  endfunction

  // Offer one stream byte after a random gap; hold valid until the transaction
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_start_code(input logic [BYTE_W-1:0] nal);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_ONE);
    send_byte(nal);
  endtask

  task automatic send_payload(input int n, input bit zeros_ok);
    repeat (n) send_byte(stream_byte(zeros_ok));
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the stream until every predicted result is out, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One NAL unit of random shape, mostly well formed
  task automatic send_unit();
    case ($urandom_range(0, 9))
      0: send_payload($urandom_range(1, 8), 1'b1);
      1: begin
        // broken start code: three-byte prefix or missing one
        send_byte(BYTE_ZERO);
        send_byte(BYTE_ZERO);
        send_byte($urandom_range(0, 1) ? BYTE_ONE : BYTE_ZERO);
        send_byte(NAL_IDR);
        send_payload($urandom_range(0, 6), 1'b1);
      end
      2: begin
        send_start_code(NAL_SPS);
        send_payload($urandom_range(0, 12), 1'b1);
      end
      3, 4, 5, 6: begin
        send_start_code(NAL_IDR);
        send_payload($urandom_range(0, 24), 1'b1);
      end
      default: begin
        send_start_code(stream_byte(1'b1));
        send_payload($urandom_range(0, 24), 1'b1);
      end
    endcase
  endtask

  initial begin : stimulus
    int random_from;
    logic [CFG_DATA_W-1:0] seg_limit;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Record with no size limit; stray bytes and a short prefix before any header
    write_reg(REG_MAX_SEGMENT_BYTES, 32'hFFFF_FFFF);
    write_reg(REG_RECORD_ENABLE, 32'd1);
    send_byte(8'hFF);
    send_byte(BYTE_ZERO);
    send_byte(NAL_SPS);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_ONE);
    send_byte(NAL_SPS);

    // Oversized header with an inner start code; the keyframe opens a segment at once
    send_start_code(NAL_SPS);
    send_payload(20, 1'b0);
    send_start_code(NAL_SLICE);
    send_payload(25, 1'b0);
    send_start_code(NAL_IDR);

    // Pass through extremes, a later header code and a keyframe under the huge limit
    send_byte(8'hFF);
    send_byte(BYTE_ZERO);
    send_start_code(NAL_SPS);
    send_start_code(NAL_IDR);
    send_payload(4, 1'b1);
    settle();

    // Smallest limit: close on the next byte and reopen at the keyframe
    write_reg(REG_MAX_SEGMENT_BYTES, 32'd1);
    send_payload(3, 1'b1);
    send_start_code(NAL_IDR);
    settle();

    // Limit reached inside the start code: two prefix bytes already passed through
    write_reg(REG_MAX_SEGMENT_BYTES, 32'd6);
    send_start_code(NAL_IDR);
    settle();

    // Disable: finish the segment at the keyframe, then ignore the stream
    write_reg(REG_RECORD_ENABLE, 32'd0);
    send_payload(6, 1'b1);
    send_start_code(NAL_IDR);
    send_payload(2, 1'b1);
    settle();

    // Enable while stopped, then disable again while waiting for a keyframe
    write_reg(REG_RECORD_ENABLE, 32'd1);
    send_payload(3, 1'b0);
    settle();
    write_reg(REG_RECORD_ENABLE, 32'd0);
    send_byte(8'h5A);
    settle();
    write_reg(REG_RECORD_ENABLE, 32'd1);
    send_payload(2, 1'b1);
    send_start_code(NAL_IDR);
    send_payload(5, 1'b1);
    settle();

    // Random phases, each with its own settings and idling behaviour
    random_from = bytes_sent;
    while (bytes_sent - random_from < RANDOM_BYTES) begin
      case ($urandom_range(0, 4))
        0:       seg_limit = 32'd1;
        1:       seg_limit = 32'hFFFF_FFFF;
        2:       seg_limit = 32'($urandom_range(5, 40));
        3:       seg_limit = 32'($urandom_range(41, 200));
        default: seg_limit = 32'($urandom_range(1, 32'hFFFF_FFFE));
      endcase
      write_reg(REG_MAX_SEGMENT_BYTES, seg_limit);
      write_reg(REG_RECORD_ENABLE, ($urandom_range(0, 7) != 0) ? 32'd1 : 32'd0);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) send_unit();
      settle();
    end

    if (fail_count == 0)
      $display("PASS h264_keyframe_segmenter");
    else
      $display("FAIL h264_keyframe_segmenter");
    $finish;
  end

endmodule
